[src/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and constants for the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int PFLA_PAGE_COUNT  = 32;
    localparam int PFLA_PAGE_SHIFT  = 12;
    localparam int PFLA_QUEUE_DEPTH = 2;
    localparam int PFLA_FC_W        = 6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_ADDR = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_NULL     = 3'd4
    } t_status;

    // request class decided by the front end
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_NULL,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_bk_state;

    typedef struct packed {
        logic        command;
        logic [31:0] page_address;
    } t_req;

    typedef struct packed {
        logic [2:0]           status;
        logic [31:0]          result_address;
        logic [PFLA_FC_W-1:0] free_count;
    } t_rsp;

endpackage

[src/pfla_front.sv]
// ----------------------------------------------------------------------------
// pfla_front
// Classifies a request word: allocate, free with page index, null free, or
// bad address (out of pool range or misaligned).
// ----------------------------------------------------------------------------
module pfla_front import pfla_pkg::*; #(
    parameter int PAGE_COUNT = PFLA_PAGE_COUNT,
    parameter int PAGE_SHIFT = PFLA_PAGE_SHIFT,
    localparam int IDX_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
    input  t_req              i_req,
    input  logic [31:0]       i_pool_base,
    output t_op               o_op,
    output logic [IDX_W-1:0]  o_idx
);

    localparam logic [32:0] SPAN = 33'(PAGE_COUNT) << PAGE_SHIFT;

    logic [32:0] diff;
    logic        in_range;
    logic        aligned;

    // 33-bit difference: bit 32 set means address below the pool base
    assign diff     = {1'b0, i_req.page_address} - {1'b0, i_pool_base};
    assign in_range = !diff[32] && (diff < SPAN);
    assign aligned  = (diff[PAGE_SHIFT-1:0] == '0);

    always_comb begin
        o_idx = '0;
        if (i_req.command == CMD_ALLOC) begin
            o_op = OP_ALLOC;
        end else if (i_req.page_address == 32'd0) begin
            o_op = OP_NULL;
        end else if (!in_range || !aligned) begin
            o_op = OP_BAD;
        end else begin
            o_op  = OP_FREE;
            o_idx = diff[PAGE_SHIFT +: IDX_W];
        end
    end

endmodule

[src/pfla_fifo.sv]
// ----------------------------------------------------------------------------
// pfla_fifo
// Short queue between the front end and the stack engine.
// ----------------------------------------------------------------------------
module pfla_fifo import pfla_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = PFLA_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underflow");

endmodule

[src/pfla_back.sv]
// ----------------------------------------------------------------------------
// pfla_back
// Stack engine: holds the free-page stack and the per-page free map, runs
// one queued request at a time and produces its result word.
// ----------------------------------------------------------------------------
module pfla_back import pfla_pkg::*; #(
    parameter int PAGE_COUNT = PFLA_PAGE_COUNT,
    parameter int PAGE_SHIFT = PFLA_PAGE_SHIFT,
    localparam int IDX_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
    localparam int TOP_W     = $clog2(PAGE_COUNT + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_pool_base,
    input  logic             i_q_valid,
    input  t_op              i_q_op,
    input  logic [IDX_W-1:0] i_q_idx,
    output logic             o_q_pop,
    output logic             o_ready,
    output logic             o_done,
    output t_rsp             o_rsp
);

    // memories
    logic [IDX_W-1:0] r_stack    [PAGE_COUNT];
    logic             r_free_map [PAGE_COUNT];

    t_bk_state        r_state, n_state;
    logic [TOP_W-1:0] r_top, n_top;
    logic [TOP_W-1:0] r_low, n_low;     // lowest stack top seen since reset
    logic [IDX_W-1:0] r_clr, n_clr;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    // request in flight
    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_stk_ra;
    logic             r_stk_fresh;
    logic [IDX_W-1:0] r_stk_rd;
    logic             r_free_rd;

    logic [TOP_W-1:0] top_m1;
    logic [IDX_W-1:0] stk_ra;
    logic             stk_we;
    logic [IDX_W-1:0] stk_wa;
    logic             free_we;
    logic [IDX_W-1:0] free_wa;
    logic             free_wd;
    logic [IDX_W-1:0] pop_idx;

    assign top_m1  = r_top - 1'b1;
    assign stk_ra  = top_m1[IDX_W-1:0];
    // slots below the low mark were never pushed, so their own index is used as the page
    assign pop_idx = r_stk_fresh ? r_stk_ra : r_stk_rd;
    assign o_q_pop = (r_state == BK_IDLE) && i_q_valid;
    assign o_ready = (r_state != BK_CLEAR);
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_state = r_state;
        n_top   = r_top;
        n_low   = r_low;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        stk_we  = 1'b0;
        stk_wa  = r_top[IDX_W-1:0];
        free_we = 1'b0;
        free_wa = r_clr;
        free_wd = 1'b1;
        case (r_state)
            BK_CLEAR: begin
                free_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IDX_W'(PAGE_COUNT - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state              = BK_IDLE;
                n_done               = 1'b1;
                n_rsp.result_address = 32'd0;
                n_rsp.status         = ST_OK;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_top == '0) begin
                            n_rsp.status = ST_EMPTY;
                        end else begin
                            n_top   = top_m1;
                            free_we = 1'b1;
                            free_wa = pop_idx;
                            free_wd = 1'b0;
                            n_rsp.result_address = i_pool_base
                                + (32'(pop_idx) << PAGE_SHIFT);
                            if (top_m1 < r_low) begin
                                n_low = top_m1;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (r_free_rd) begin
                            n_rsp.status = ST_DOUBLE;
                        end else begin
                            if (r_top < TOP_W'(PAGE_COUNT)) begin
                                stk_we = 1'b1;
                                n_top  = r_top + 1'b1;
                            end
                            free_we = 1'b1;
                            free_wa = r_idx;
                            free_wd = 1'b1;
                        end
                    end
                    OP_NULL: n_rsp.status = ST_NULL;
                    OP_BAD:  n_rsp.status = ST_BAD_ADDR;
                    default: n_rsp.status = ST_BAD_ADDR;
                endcase
                n_rsp.free_count = PFLA_FC_W'(n_top);
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_top   <= TOP_W'(PAGE_COUNT);
            r_low   <= TOP_W'(PAGE_COUNT);
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_low   <= n_low;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (o_q_pop) begin
            r_op        <= i_q_op;
            r_idx       <= i_q_idx;
            r_stk_ra    <= stk_ra;
            r_stk_fresh <= (top_m1 < r_low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= r_idx;
        end
        if (o_q_pop) begin
            r_stk_rd <= r_stack[stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_free_map[free_wa] <= free_wd;
        end
        if (o_q_pop) begin
            r_free_rd <= r_free_map[i_q_idx];
        end
    end

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(PAGE_COUNT)) else $error("stack top beyond pool");
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top) else $error("low mark above stack top");
    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == BK_EXEC)) else $error("dequeue without execute");
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == BK_EXEC)) else $error("stray result strobe");

endmodule

[src/page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO page allocator over a fixed pool of frames; allocates and frees pages
// by byte address and reports a status and the free count for each request.
//
//   channel   ports                          handshake
//   request   i_req                          start, busy
//   result    o_rsp                          o_done (one-cycle strobe)
//   config    i_cfg_data (pool_base)         i_cfg_we
//
// A request is classified on entry and queued; the stack engine takes one
// queued request at a time (memory read in the idle state, then update in
// the execute state) and finishes it before taking the next. The result
// word and o_done are registered from the execute state. After reset a
// clearing pass marks every page free in the free map while busy is high.
// busy is also high while the queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
module page_free_list_allocator import pfla_pkg::*; #(
    parameter int PAGE_COUNT = PFLA_PAGE_COUNT,
    parameter int PAGE_SHIFT = PFLA_PAGE_SHIFT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int Q_W   = $bits(t_op) + IDX_W;

    logic [31:0]      r_pool_base;
    t_op              f_op;
    logic [IDX_W-1:0] f_idx;
    logic             q_push;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    logic             q_empty;
    logic             q_full;
    logic             bk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= 32'd0;
        end else if (i_cfg_we) begin
            r_pool_base <= i_cfg_data;
        end
    end

    assign busy   = q_full || !bk_ready;
    assign q_push = start && !busy;

    pfla_front #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_req       (i_req),
        .i_pool_base (r_pool_base),
        .o_op        (f_op),
        .o_idx       (f_idx)
    );

    pfla_fifo #(
        .WIDTH (Q_W),
        .DEPTH (PFLA_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_op, f_idx}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pfla_back #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_base (r_pool_base),
        .i_q_valid   (!q_empty),
        .i_q_op      (t_op'(q_data[Q_W-1 -: $bits(t_op)])),
        .i_q_idx     (q_data[IDX_W-1:0]),
        .o_q_pop     (q_pop),
        .o_ready     (bk_ready),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
